>>> rtl/bal_pkg.sv
// Shared types, codes and defaults for the bounded array list.
package bal_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int KIND_W  = 3;
    localparam int POS_W   = 5;
    localparam int ITEM_W  = 32;
    localparam int COUNT_W = 5;

    localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GET    = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        logic [ITEM_W-1:0] item;
    } bal_req_t;

    typedef struct packed {
        logic               ok;
        logic [ITEM_W-1:0]  read_word;
        logic [COUNT_W-1:0] count;
        logic               is_full;
        logic               is_empty;
    } bal_rsp_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } bal_mem_ctl_t;

endpackage

>>> rtl/bal_store.sv
// Slot memory: one write port, one read port with registered read data.
module bal_store #(
    parameter int DEPTH = bal_pkg::CAPACITY_DEF,
    parameter int WIDTH = bal_pkg::WORD_BITS_DEF
) (
    input  logic                     aclk,
    input  bal_pkg::bal_mem_ctl_t    mem_ctl,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    import bal_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_ctl.wr_en) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_ctl.rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bal_ctrl.sv
// Request sequencer: decode, shift loop over the slot memory, result register.
module bal_ctrl #(
    parameter int CAPACITY  = bal_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = bal_pkg::WORD_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  bal_pkg::bal_req_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output bal_pkg::bal_rsp_t           m_data,
    output bal_pkg::bal_mem_ctl_t       mem_ctl,
    output logic [$clog2(CAPACITY)-1:0] waddr,
    output logic [WORD_BITS-1:0]        wdata,
    output logic [$clog2(CAPACITY)-1:0] raddr,
    input  logic [WORD_BITS-1:0]        rdata
);
    import bal_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int MINW = (WORD_BITS < ITEM_W) ? WORD_BITS : ITEM_W;

    localparam logic [AW-1:0]   LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [CMPW-1:0] CAP_CMP  = CMPW'(CAPACITY);
    localparam logic [CW-1:0]   CAP_CNT  = CW'(CAPACITY);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_WR    = 3'd4;
    localparam logic [2:0] ST_LAST  = 3'd5;
    localparam logic [2:0] ST_GET   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        count_reg, count_next;
    bal_req_t             req_reg, req_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic                 ok_reg, ok_next;
    logic                 m_valid_reg, m_valid_next;
    bal_rsp_t             m_data_reg, m_data_next;

    logic [CMPW-1:0]      pos_ext;
    logic [CMPW-1:0]      cnt_ext;
    logic                 is_insert;
    logic [AW-1:0]        step;
    logic [AW-1:0]        bound;
    logic [WORD_BITS-1:0] item_w;
    logic [ITEM_W-1:0]    word_out;

    assign pos_ext   = CMPW'(req_reg.position);
    assign cnt_ext   = CMPW'(count_reg);
    assign is_insert = (req_reg.kind == KIND_INSERT);
    assign step      = is_insert ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
    assign bound     = is_insert ? pos_ext[AW-1:0] : LAST_IDX;

    always_comb begin
        item_w = '0;
        item_w[MINW-1:0] = req_reg.item[MINW-1:0];
        word_out = '0;
        word_out[MINW-1:0] = word_reg[MINW-1:0];
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        req_next     = req_reg;
        word_next    = word_reg;
        ok_next      = ok_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mem_ctl      = '0;
        waddr        = idx_reg;
        wdata        = '0;
        raddr        = step;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_ctl.wr_en = 1'b1;
                idx_next      = idx_reg + AW'(1);
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ok_next    = 1'b0;
                word_next  = '0;
                state_next = ST_DONE;
                case (req_reg.kind)
                    KIND_PUSH: begin
                        if (cnt_ext < CAP_CMP) begin
                            mem_ctl.wr_en = 1'b1;
                            waddr         = count_reg[AW-1:0];
                            wdata         = item_w;
                            count_next    = count_reg + CW'(1);
                            ok_next       = 1'b1;
                        end
                    end
                    KIND_INSERT: begin
                        if (cnt_ext < CAP_CMP && pos_ext <= cnt_ext) begin
                            count_next = count_reg + CW'(1);
                            ok_next    = 1'b1;
                            idx_next   = LAST_IDX;
                            state_next = (pos_ext[AW-1:0] == LAST_IDX) ? ST_LAST : ST_RD;
                        end
                    end
                    KIND_POP: begin
                        if (count_reg != '0) begin
                            count_next = count_reg - CW'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    KIND_REMOVE: begin
                        if (pos_ext < cnt_ext) begin
                            count_next = count_reg - CW'(1);
                            ok_next    = 1'b1;
                            idx_next   = pos_ext[AW-1:0];
                            state_next = (pos_ext[AW-1:0] == LAST_IDX) ? ST_LAST : ST_RD;
                        end
                    end
                    KIND_GET: begin
                        if (pos_ext < CAP_CMP) begin
                            mem_ctl.rd_en = 1'b1;
                            raddr         = pos_ext[AW-1:0];
                            ok_next       = 1'b1;
                            state_next    = ST_GET;
                        end
                    end
                    default: begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            ST_RD: begin
                mem_ctl.rd_en = 1'b1;
                state_next    = ST_WR;
            end
            ST_WR: begin
                mem_ctl.wr_en = 1'b1;
                wdata         = rdata;
                idx_next      = step;
                state_next    = (step == bound) ? ST_LAST : ST_RD;
            end
            ST_LAST: begin
                mem_ctl.wr_en = 1'b1;
                wdata         = is_insert ? item_w : '0;
                state_next    = ST_DONE;
            end
            ST_GET: begin
                word_next  = rdata;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.ok        = ok_reg;
                    m_data_next.read_word = word_out;
                    m_data_next.count     = COUNT_W'(count_reg);
                    m_data_next.is_full   = (count_reg == CAP_CNT);
                    m_data_next.is_empty  = (count_reg == '0);
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        word_reg   <= word_next;
        ok_reg     <= ok_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/bounded_array_list_top.sv
// Top level of the bounded array list: sequencer plus slot memory.
//
// Requests arrive on the s_ channel (kind, position, item) and each one yields
// exactly one result beat on the m_ channel (ok, read_word, count, is_full,
// is_empty). Both channels use valid/ready; a beat moves when both are high.
// The block works on one request at a time and drops s_ready while busy.
// Push, pop and rejected requests go from decode straight to the result state;
// get adds a read of the slot memory; insert and remove that are accepted run
// the shift loop where slots must move, then a final slot write.
// The shift loop runs one read and one write per moved slot through the single
// port pair of the slot memory.
// The block returns to the idle state before the next request is taken.
// After reset the block sweeps the slot memory to zero, one slot per cycle,
// with s_ready low, then goes idle with an empty list.
// The result sits in an output register; a stalled receiver holds it there,
// and a finished request waits for that register before the next is taken.
module bounded_array_list_top #(
    parameter int CAPACITY  = bal_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = bal_pkg::WORD_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bal_pkg::bal_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bal_pkg::bal_rsp_t m_data
);
    import bal_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    bal_mem_ctl_t         mem_ctl;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic [WORD_BITS-1:0] wdata;
    logic [WORD_BITS-1:0] rdata;

    bal_ctrl #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .mem_ctl (mem_ctl),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr   (raddr),
        .rdata   (rdata)
    );

    bal_store #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_BITS)
    ) u_store (
        .aclk    (aclk),
        .mem_ctl (mem_ctl),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr   (raddr),
        .rdata   (rdata)
    );

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.is_full && m_data.is_empty))
        else $error("full and empty reported together");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.read_word != '0) |-> m_data.ok)
        else $error("nonzero read word on a failed request");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mem_ctl.wr_en)
        else $error("slot write while idle");

    assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("ready right after reset, before the clearing sweep");
`endif

endmodule
